// ===== rtl/arp_pkg.sv =====
// Package for the note arpeggiator: codes, state encoding and the
// command/status bundles that join the controller and the datapath.
// No dependencies.
package arp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NoteInW = 7;
  localparam int unsigned NoteOutW = 8;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_NOTE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] MODE_UP     = 3'd0;
  localparam logic [2:0] MODE_DOWN   = 3'd1;
  localparam logic [2:0] MODE_UPDOWN = 3'd2;
  localparam logic [2:0] MODE_RANDOM = 3'd3;
  localparam logic [2:0] MODE_STRUM  = 3'd4;
  localparam logic [2:0] MODE_HOLD   = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPAN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESTART = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INC     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SYNC    = 3'd4;

  localparam logic [NoteOutW-1:0] SEMITONES = 8'd12;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DIV,
    ST_MAP,
    ST_OCT,
    ST_OUT
  } arp_state_e;

  typedef struct packed {
    logic accept;
    logic ins_rd;
    logic ins_put;
    logic ins_cmp;
    logic div_step;
    logic map;
    logic oct_step;
    logic rd;
    logic out_load;
  } arp_cmd_t;

  typedef struct packed {
    logic need_ins;
    logic need_emit;
    logic pos_zero;
    logic ins_shift;
    logic div_last;
    logic oct_done;
    logic out_free;
  } arp_status_t;

endpackage

// ===== rtl/arp_if.sv =====
// Channel interfaces of the note arpeggiator: input requests, results and
// configuration writes. Depends on arp_pkg.
interface arp_in_if
  import arp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [NoteInW-1:0] note_in;
  logic               chord_last;
  modport source (output valid, output operation, output note_in, output chord_last,
                  input ready);
  modport sink (input valid, input operation, input note_in, input chord_last,
                output ready);
endinterface

interface arp_out_if
  import arp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NoteOutW-1:0] note_out;
  modport source (output valid, output note_out, input ready);
  modport sink (input valid, input note_out, output ready);
endinterface

interface arp_cfg_if
  import arp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/note_arpeggiator.sv =====
// Note arpeggiator. Requests are handled one at a time. A tick that does not
// complete a step, a chord clear, or a chord note into a full store is finished
// when it is accepted. A chord note makes one memory read and one
// compare-and-write for each stored note it moves past, then a write when it
// lands at the bottom of the store or a read and a compare-and-write when a
// compare stops it. A tick that completes a step is accepted, then passes the
// bit-serial remainder unit that reduces the step count (or the LFSR value) by
// the pattern length, a map step, the octave split, one chord memory read, and
// the load of the output register, which waits while an earlier result is still
// held. A finished result sits in that register, so the next request is taken
// while it waits. No clearing pass.
module note_arpeggiator
  import arp_pkg::*;
#(
  parameter int unsigned MAX_NOTES   = 16,
  parameter int unsigned MAX_OCTAVES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  arp_cfg_if.sink   cfg_i,
  arp_in_if.sink    in_i,
  arp_out_if.source out_o
);

  arp_cmd_t    cmd;
  arp_status_t st;

  arp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  arp_dp #(
    .MAX_NOTES   (MAX_NOTES),
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .operation_i  (in_i.operation),
    .note_in_i    (in_i.note_in),
    .chord_last_i (in_i.chord_last),
    .out_o        (out_o),
    .cmd_i        (cmd),
    .st_o         (st)
  );

`ifndef SYNTH
  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result overwritten");

  // A request that starts a chord insertion or a step emission blocks the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (st.need_ins || st.need_emit)) |=> !in_i.ready)
    else $error("request taken while busy");

  // A result appears only after the controller loads one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load))
    else $error("result without load");
`endif

endmodule

// ===== rtl/arp_ctrl.sv =====
// Controller state machine of the note arpeggiator: sequences insertion,
// the remainder unit, octave split and result load. Depends on arp_pkg.
module arp_ctrl
  import arp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  arp_status_t st_i,
  output arp_cmd_t    cmd_o
);

  arp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (st_i.need_ins) begin
            state_d = ST_INS_RD;
          end else if (st_i.need_emit) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_INS_RD: begin
        if (st_i.pos_zero) begin
          cmd_o.ins_put = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        cmd_o.ins_cmp = 1'b1;
        state_d       = st_i.ins_shift ? ST_INS_RD : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = ST_OCT;
      end
      ST_OCT: begin
        if (st_i.oct_done) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_OUT;
        end else begin
          cmd_o.oct_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/arp_dp.sv =====
// Datapath of the note arpeggiator: configuration registers, chord memory,
// phase accumulator, LFSR, bit-serial remainder unit and result register.
// Depends on arp_pkg and arp_if.
module arp_dp
  import arp_pkg::*;
#(
  parameter int unsigned MAX_NOTES   = 16,
  parameter int unsigned MAX_OCTAVES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  arp_cfg_if.sink            cfg_i,
  input  logic [1:0]         operation_i,
  input  logic [NoteInW-1:0] note_in_i,
  input  logic               chord_last_i,
  arp_out_if.source          out_o,
  input  arp_cmd_t           cmd_i,
  output arp_status_t        st_o
);

  localparam int unsigned IdxW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned CntW = $clog2(MAX_NOTES + 1);
  localparam int unsigned DvrW = $clog2(2 * MAX_NOTES * MAX_OCTAVES);
  localparam int unsigned OctW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  // Configuration.
  logic [2:0]       mode_q;
  logic [2:0]       span_q;
  logic             restart_q;
  logic [DataW-1:0] inc_q;
  logic [1:0]       sync_q;

  // Arpeggiator state.
  logic [CntW-1:0]    count_q;
  logic               open_q;
  logic [DataW-1:0]   step_q;
  logic [DataW-1:0]   phase_q;
  logic [15:0]        lfsr_q;
  logic [CntW-1:0]    pos_q;
  logic [NoteInW-1:0] note_q;

  // Remainder unit and mapping.
  logic [DataW-1:0] dvd_q;
  logic [DvrW-1:0]  dvr_q;
  logic [DvrW-1:0]  rem_q;
  logic [DvrW-1:0]  uplen_q;
  logic [4:0]       dcnt_q;
  logic [DvrW-1:0]  j_q;
  logic [OctW-1:0]  oct_q;

  logic [NoteInW-1:0] mem [MAX_NOTES];
  logic [NoteInW-1:0] rd_q;

  logic                out_valid_q;
  logic [NoteOutW-1:0] note_out_q;

  // Combinational helpers.
  logic [CntW-1:0]  eff_cnt;
  logic             active;
  logic [DataW:0]   sum;
  logic [DataW-1:0] inc;
  logic             lfsr_bit;
  logic [15:0]      lfsr_n;
  logic [DvrW-1:0]  span_c;
  logic [DvrW-1:0]  n_c;
  logic [DvrW-1:0]  uplen_c;
  logic [DvrW-1:0]  dvr_c;
  logic [DvrW:0]    rem_sh;
  logic [DvrW-1:0]  rem_n;
  logic [DvrW-1:0]  j_c;
  logic             accept_note;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (span_q == 3'd0) begin
      span_c = DvrW'(1);
    end else if ({1'b0, span_q} > 4'(MAX_OCTAVES)) begin
      span_c = DvrW'(MAX_OCTAVES);
    end else begin
      span_c = DvrW'(span_q);
    end
  end

  assign n_c      = DvrW'(count_q);
  assign uplen_c  = DvrW'(n_c * span_c);
  assign eff_cnt  = open_q ? count_q : '0;
  assign active   = (count_q != '0) && (mode_q < MODE_HOLD);
  assign inc      = inc_q >> sync_q;
  assign sum      = {1'b0, phase_q} + {1'b0, inc};
  assign lfsr_bit = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_n   = {lfsr_bit, lfsr_q[15:1]};
  assign accept_note = cmd_i.accept && (operation_i == OP_NOTE);

  always_comb begin
    case (mode_q)
      MODE_UP, MODE_DOWN: dvr_c = uplen_c;
      MODE_UPDOWN: dvr_c = (span_c == DvrW'(1)) ? uplen_c : DvrW'((uplen_c << 1) - n_c);
      default: dvr_c = n_c;
    endcase
  end

  assign rem_sh = {rem_q, dvd_q[DataW-1]};
  assign rem_n  = (rem_sh >= {1'b0, dvr_q}) ? DvrW'(rem_sh - {1'b0, dvr_q}) : DvrW'(rem_sh);

  // Descending sections read the pattern backwards from the period end.
  always_comb begin
    case (mode_q)
      MODE_DOWN: j_c = dvr_q - DvrW'(1) - rem_q;
      MODE_UPDOWN: j_c = (rem_q < uplen_q) ? rem_q : dvr_q - DvrW'(1) - rem_q;
      default: j_c = rem_q;
    endcase
  end

  assign st_o.need_ins  = (operation_i == OP_NOTE) && (eff_cnt < CntW'(MAX_NOTES));
  assign st_o.need_emit = (operation_i == OP_TICK) && active && sum[DataW];
  assign st_o.pos_zero  = (pos_q == '0);
  assign st_o.ins_shift = (rd_q > note_q);
  assign st_o.div_last  = (dcnt_q == 5'd31);
  assign st_o.oct_done  = (j_q < n_c);
  assign st_o.out_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_UP;
      span_q    <= 3'd1;
      restart_q <= 1'b0;
      inc_q     <= '0;
      sync_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODE:    mode_q    <= cfg_i.data[2:0];
        CFG_SPAN:    span_q    <= cfg_i.data[2:0];
        CFG_RESTART: restart_q <= cfg_i.data[0];
        CFG_INC:     inc_q     <= cfg_i.data;
        CFG_SYNC:    sync_q    <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      open_q      <= 1'b0;
      step_q      <= '0;
      phase_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        case (operation_i)
          OP_NOTE: begin
            count_q <= eff_cnt;
            open_q  <= !chord_last_i;
            if (chord_last_i && restart_q) begin
              step_q  <= '0;
              phase_q <= '0;
            end
          end
          OP_CLEAR: begin
            count_q <= '0;
            open_q  <= 1'b0;
            if (restart_q) begin
              step_q  <= '0;
              phase_q <= '0;
            end
          end
          OP_TICK: begin
            if (active) begin
              phase_q <= sum[DataW-1:0];
              if (sum[DataW]) begin
                step_q <= step_q + 1'b1;
                if (mode_q == MODE_RANDOM) begin
                  lfsr_q <= lfsr_n;
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.ins_put || (cmd_i.ins_cmp && !st_o.ins_shift)) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_note) begin
      pos_q  <= eff_cnt;
      note_q <= note_in_i;
    end
    if (cmd_i.ins_cmp && st_o.ins_shift) begin
      pos_q <= pos_q - 1'b1;
    end
    if (cmd_i.accept) begin
      dvd_q   <= (mode_q == MODE_RANDOM) ? DataW'(lfsr_n) : step_q + 1'b1;
      dvr_q   <= dvr_c;
      uplen_q <= uplen_c;
      rem_q   <= '0;
      dcnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_n;
      dvd_q  <= dvd_q << 1;
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.map) begin
      j_q   <= j_c;
      oct_q <= '0;
    end
    if (cmd_i.oct_step) begin
      j_q   <= j_q - n_c;
      oct_q <= oct_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      note_out_q <= NoteOutW'(rd_q) + NoteOutW'(NoteOutW'(oct_q) * SEMITONES);
    end
  end

  // Chord memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_put || cmd_i.ins_cmp) begin
      mem[pos_q[IdxW-1:0]] <= (cmd_i.ins_cmp && st_o.ins_shift) ? rd_q : note_q;
    end
    if (cmd_i.ins_rd) begin
      rd_q <= mem[IdxW'(pos_q - 1'b1)];
    end else if (cmd_i.rd) begin
      rd_q <= mem[j_q[IdxW-1:0]];
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.note_out = note_out_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the note arpeggiator: chord loading, the phase
// accumulator and every pattern mode, checked against an in-bench predictor.
// Depends on arp_pkg, the channel interfaces in rtl/arp_if.sv and the RTL.
module testbench;
  import arp_pkg::*;

  localparam int unsigned NotesMax   = 16;
  localparam int unsigned OctavesMax = 4;
  localparam int unsigned StallLimit = 20000;

  logic clk_i;
  logic rst_ni;

  arp_cfg_if cfg_ch();
  arp_in_if  req_ch();
  arp_out_if note_ch();

  note_arpeggiator #(.MAX_NOTES(NotesMax), .MAX_OCTAVES(OctavesMax)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (req_ch.sink),
    .out_o (note_ch.source)
  );

  // Predictor state.
  logic [2:0]  p_mode;
  logic [2:0]  p_span;
  logic        p_restart;
  logic [31:0] p_inc;
  logic [1:0]  p_sync;
  logic [6:0]  p_chord [NotesMax];
  int unsigned p_count;
  logic        p_open;
  logic [31:0] p_step;
  logic [31:0] p_phase;
  logic [15:0] p_lfsr;

  logic [7:0] note_queue[$];
  int unsigned fail_count;
  int unsigned note_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [7:0] ascending_note(input int unsigned j);
    return 8'(p_chord[j % p_count]) + 8'(12 * (j / p_count));
  endfunction

  function automatic logic [7:0] next_arp_note();
    int unsigned span_eff;
    int unsigned up_len;
    int unsigned down_len;
    int unsigned idx;
    logic        fb;
    span_eff = (p_span == 0) ? 1 : ((p_span > OctavesMax) ? OctavesMax : p_span);
    up_len   = p_count * span_eff;
    case (p_mode)
      MODE_UP: return ascending_note(p_step % up_len);
      MODE_DOWN: return ascending_note(up_len - 1 - (p_step % up_len));
      MODE_UPDOWN: begin
        down_len = p_count * (span_eff - 1);
        idx = p_step % (up_len + down_len);
        if (idx < up_len) return ascending_note(idx);
        return ascending_note(down_len - 1 - (idx - up_len));
      end
      MODE_RANDOM: begin
        fb = p_lfsr[0] ^ p_lfsr[2] ^ p_lfsr[3] ^ p_lfsr[5];
        p_lfsr = {fb, p_lfsr[15:1]};
        return 8'(p_chord[p_lfsr % p_count]);
      end
      default: return 8'(p_chord[p_step % p_count]);
    endcase
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [6:0] note,
                                 input logic last);
    int unsigned pos;
    logic [31:0] add;
    if (op == OP_NOTE) begin
      if (!p_open) begin
        p_count = 0;
        p_open  = 1'b1;
      end
      if (p_count < NotesMax) begin
        pos = p_count;
        while (pos > 0 && p_chord[pos-1] > note) begin
          p_chord[pos] = p_chord[pos-1];
          pos--;
        end
        p_chord[pos] = note;
        p_count++;
      end
      if (last) begin
        p_open = 1'b0;
        if (p_restart) begin
          p_step  = '0;
          p_phase = '0;
        end
      end
    end else if (op == OP_CLEAR) begin
      p_count = 0;
      p_open  = 1'b0;
      if (p_restart) begin
        p_step  = '0;
        p_phase = '0;
      end
    end else if (op == OP_TICK) begin
      if (p_count != 0 && p_mode < MODE_HOLD) begin
        add = p_inc >> p_sync;
        p_phase = p_phase + add;
        if (p_phase < add) begin
          p_step++;
          note_queue.insert(note_queue.size(), next_arp_note());
        end
      end
    end
  endtask

  // Valid stays high after an accepted request; the next request replaces it, or a
  // pause or a drain drops it, so requests can follow back to back.
  task automatic send_request(input logic [1:0] op, input logic [6:0] note,
                              input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.note_in    <= note;
    req_ch.chord_last <= last;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_request(op, note, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (note_queue.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_MODE:    p_mode    = val[2:0];
      CFG_SPAN:    p_span    = val[2:0];
      CFG_RESTART: p_restart = val[0];
      CFG_INC:     p_inc     = val;
      CFG_SYNC:    p_sync    = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_pattern(input logic [2:0] mode, input logic [2:0] span,
                             input logic restart, input logic [31:0] inc,
                             input logic [1:0] sync);
    wait_drained();
    write_register(CFG_MODE, 32'(mode));
    write_register(CFG_SPAN, 32'(span));
    write_register(CFG_RESTART, 32'(restart));
    write_register(CFG_INC, inc);
    write_register(CFG_SYNC, 32'(sync));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_chord(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_request(OP_NOTE, 7'($urandom_range(127)), i == n - 1);
  endtask

  task automatic test_directed();
    set_pattern(MODE_UP, 3'd2, 1'b1, 32'h8000_0000, 2'd0);
    send_request(OP_TICK, 7'd0, 1'b0);   // empty chord emits nothing
    send_request(OP_NOTE, 7'd127, 1'b0);
    send_request(OP_NOTE, 7'd0, 1'b0);
    send_request(OP_TICK, 7'd0, 1'b0);   // tick while the load is open
    send_request(OP_TICK, 7'd0, 1'b0);
    send_request(OP_NOTE, 7'd64, 1'b1);
    send_request(2'd3, 7'h7f, 1'b1);     // unused operation is ignored
    for (int i = 0; i < 8; i++) send_request(OP_TICK, 7'd0, 1'b0);
    // Overfill the store so the late notes are dropped.
    for (int i = 0; i < 18; i++) send_request(OP_NOTE, 7'(127 - i * 7), i == 17);
    for (int i = 0; i < 4; i++) send_request(OP_TICK, 7'd0, 1'b0);
    send_request(OP_CLEAR, 7'd0, 1'b0);
    send_request(OP_TICK, 7'd0, 1'b0);
  endtask

  task automatic test_modes();
    for (int m = 0; m < 8; m++) begin
      set_pattern(3'(m), 3'(m), 1'(m), 32'hFFFF_FFFF - 32'(m), 2'(m));
      load_chord($urandom_range(1, 5));
      for (int i = 0; i < 12; i++) send_request(OP_TICK, 7'd0, 1'b0);
    end
  endtask

  task automatic random_traffic(input int unsigned items);
    int unsigned r;
    for (int unsigned i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 70) send_request(OP_TICK, 7'($urandom), 1'($urandom));
      else if (r < 93) send_request(OP_NOTE, 7'($urandom), $urandom_range(5) == 0);
      else if (r < 97) send_request(OP_CLEAR, 7'($urandom), 1'($urandom));
      else send_request(2'd3, 7'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 11;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_pattern(3'($urandom_range(7)), 3'($urandom_range(7)), 1'($urandom),
                  $urandom_range(1, 3) == 1 ? 32'hFFFF_FFFF : $urandom, 2'($urandom));
      load_chord($urandom_range(1, 8));
      random_traffic(200);
    end
  endtask

  task automatic test_backpressure();
    set_pattern(MODE_STRUM, 3'd1, 1'b0, 32'hFFFF_FFFF, 2'd0);
    load_chord(3);
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send_request(OP_TICK, 7'd0, 1'b0);
    wait_drained();
  endtask

  // Long receive stall, counted in cycles here so the sender keeps pushing.
  initial begin
    wait (hold_off);
    repeat (400) @(negedge clk_i);
    hold_off = 1'b0;
  end

  always @(negedge clk_i) begin
    note_ch.ready <= !hold_off && !(recv_idle_pct != 0 &&
                                    $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && note_ch.valid && note_ch.ready) begin
      note_count++;
      if (note_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected note %0d", note_ch.note_out));
      end else begin
        if (note_ch.note_out !== note_queue[0])
          report_mismatch($sformatf("note_out %0d, predicted %0d",
                                    note_ch.note_out, note_queue[0]));
        void'(note_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles with no accepted request, result or configuration write, paused while hold_off is set.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (note_ch.valid && note_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_TICK;
    req_ch.note_in = '0;
    req_ch.chord_last = 1'b0;
    note_ch.ready = 1'b0;
    hold_off = 1'b0;
    fail_count = 0;
    note_count = 0;
    idle_cycles = 0;
    send_idle_pct = 11;
    recv_idle_pct = 73;
    p_mode = MODE_UP;
    p_span = 3'd1;
    p_restart = 1'b0;
    p_inc = '0;
    p_sync = '0;
    p_count = 0;
    p_open = 1'b0;
    p_step = '0;
    p_phase = '0;
    p_lfsr = LFSR_SEED;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_modes();
    test_random_phases();
    test_backpressure();
    wait_drained();
    $display("Covered all pattern modes, chord loads and clears, overfull stores,");
    $display("and stalls on both sides; %0d notes checked.", note_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
